// ===== hdl/pnfd_pkg.sv =====
package pnfd_pkg;

  // Counter widths
  localparam int POS_W = 13;
  localparam int IDX_W = 10;

  // Frame geometry
  localparam int FRAME_BYTES_N = 4159;
  localparam int PN_PERIOD_N   = 1023;
  localparam int START_BIT_N   = 60;
  localparam int KEY_END_BIT_N = 33270;

  localparam int KEY_END_BYTE_N = (KEY_END_BIT_N / 8 < FRAME_BYTES_N) ?
                                  KEY_END_BIT_N / 8 : FRAME_BYTES_N;
  localparam int FIRST_BYTE_N   = START_BIT_N / 8;
  localparam int FIRST_BITS_N   = 8 - START_BIT_N % 8;

  localparam logic [POS_W-1:0] FRAME_BYTES  = POS_W'(FRAME_BYTES_N);
  localparam logic [POS_W-1:0] KEY_END_BYTE = POS_W'(KEY_END_BYTE_N);
  localparam logic [POS_W-1:0] FIRST_BYTE   = POS_W'(FIRST_BYTE_N);
  localparam logic [3:0]       FIRST_BITS   = 4'(FIRST_BITS_N);
  localparam logic [3:0]       FULL_BITS    = 4'd8;

  // Pattern period at sum width (index plus up to eight bits)
  localparam logic [IDX_W:0] PN_PERIOD   = (IDX_W+1)'(PN_PERIOD_N);
  localparam logic [IDX_W:0] PN_PERIOD_2 = (IDX_W+1)'(2 * PN_PERIOD_N);

  // Register word address (paddr[2])
  localparam logic REG_ENABLE = 1'b0;

  // Request from the counter stage to the key generator
  typedef struct packed {
    logic [IDX_W-1:0] idx;    // first pattern bit of this word
    logic             first;  // partial word at the start of the key region
  } key_req_t;

  // 1023-bit pseudo-noise pattern, MSB first
  localparam logic [7:0] PN_ROM [128] = '{
    8'h07, 8'h40, 8'hc9, 8'h29, 8'h42, 8'h5e, 8'hee, 8'ha8, 8'hee, 8'h2c, 8'h2f, 8'hb1,
    8'hf5, 8'h24, 8'h21, 8'hc8, 8'he6, 8'h60, 8'h36, 8'h6c, 8'h5c, 8'h79, 8'h6f, 8'h04,
    8'h9c, 8'hed, 8'h36, 8'haa, 8'hfd, 8'h2a, 8'h58, 8'hdb, 8'ha2, 8'h77, 8'h92, 8'hd6,
    8'h45, 8'h20, 8'h07, 8'hc4, 8'h08, 8'hb4, 8'h98, 8'hcb, 8'h3a, 8'h44, 8'h29, 8'h84,
    8'hff, 8'hbd, 8'h9f, 8'h31, 8'h12, 8'hb5, 8'h15, 8'h89, 8'h9c, 8'h2b, 8'h97, 8'hf9,
    8'hca, 8'hf5, 8'h66, 8'h41, 8'h06, 8'h0b, 8'h2a, 8'hdc, 8'h1a, 8'h3f, 8'had, 8'h07,
    8'h02, 8'ha9, 8'he7, 8'haf, 8'h14, 8'h04, 8'hde, 8'h8d, 8'hf8, 8'h47, 8'hb7, 8'hc0,
    8'h2e, 8'hb8, 8'h76, 8'h1f, 8'h94, 8'he3, 8'h4f, 8'hb9, 8'hb9, 8'h3d, 8'hfc, 8'h61,
    8'hbb, 8'h2e, 8'hfa, 8'h16, 8'hd1, 8'h79, 8'ha9, 8'ha5, 8'hcf, 8'hda, 8'he9, 8'h94,
    8'h67, 8'h8e, 8'h24, 8'h63, 8'ha8, 8'h28, 8'h8d, 8'h7c, 8'h86, 8'h2a, 8'h1a, 8'hbb,
    8'h6c, 8'h9a, 8'hd8, 8'h3c, 8'h33, 8'h43, 8'hd3, 8'hac
  };

  // One pattern bit, MSB of each ROM byte first
  function automatic logic rom_bit(input logic [IDX_W-1:0] idx);
    logic [7:0] row;
    row = PN_ROM[idx[IDX_W-1:3]];
    return row[3'd7 - idx[2:0]];
  endfunction

endpackage

// ===== hdl/pn_frame_derandomizer_unit.sv =====
// Strips a fixed 1023-bit pseudo-noise key from an aligned frame, one byte per word. tuser
// marks byte 0 of a frame; the key starts at frame bit 60 (low nibble of byte 7) and covers
// bytes up to 4157, wrapping the pattern every 1023 bits; all other bytes pass unchanged and
// come out with tuser low. Until the first frame start after reset, bytes pass unchanged.
// Throughput is one word per clock while the output accepts; a word accepted on the input
// passes the stage 1 register (word and key request) and then the key lookup and output
// register stage before it is offered on the output.
// The enable register at address 0 (reset 1) may only be written while the block is empty.
module pn_frame_derandomizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]  m_axis_tuser,   // [0] keyed
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pnfd_pkg::*;

  logic             enable_q;
  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [IDX_W-1:0] idx_q, idx_d, idx_eff;
  logic [IDX_W:0]   idx_sum;
  logic [3:0]       step;
  logic             in_accept, in_region, is_first;

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_keyed_q;
  key_req_t         s1_req_q;
  logic [7:0]       key;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_keyed_q;
  logic             out_load;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENABLE) begin
      enable_q <= pwdata[0];
    end
  end

  // Handshake: advance stages whenever the next one frees up
  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || out_load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Frame position and pattern index for this word
  always_comb begin
    pos_eff   = s_axis_tuser[0] ? '0 : pos_q;
    idx_eff   = s_axis_tuser[0] ? '0 : idx_q;
    in_region = (pos_eff >= FIRST_BYTE) && (pos_eff < KEY_END_BYTE);
    is_first  = (pos_eff == FIRST_BYTE);
    step      = is_first ? FIRST_BITS : FULL_BITS;
    idx_sum   = {1'b0, idx_eff} + (IDX_W+1)'(step);
    if (idx_sum >= PN_PERIOD_2) begin
      idx_sum = idx_sum - PN_PERIOD_2;
    end else if (idx_sum >= PN_PERIOD) begin
      idx_sum = idx_sum - PN_PERIOD;
    end
    idx_d = in_region ? idx_sum[IDX_W-1:0] : idx_eff;
    pos_d = (pos_eff < FRAME_BYTES) ? pos_eff + POS_W'(1) : pos_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= FRAME_BYTES;
      idx_q <= '0;
    end else if (in_accept) begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

  // Stage 1: hold the word and its key request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q      <= s_axis_tdata;
      s1_keyed_q     <= in_region && enable_q;
      s1_req_q.idx   <= idx_eff;
      s1_req_q.first <= is_first;
    end
  end

  pnfd_key_gen u_key_gen (
    .req_i (s1_req_q),
    .key_o (key)
  );

  // Stage 2: apply the key into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q  <= s1_keyed_q ? (s1_byte_q ^ key) : s1_byte_q;
      out_keyed_q <= s1_keyed_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tuser[0] = out_keyed_q;

  // Checks
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < PN_PERIOD[IDX_W-1:0])
    else $error("pattern index out of period");

  a_pos_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FRAME_BYTES)
    else $error("byte position past saturation");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && s_axis_tuser[0] |=> s1_req_q.idx == '0 && !s1_req_q.first)
    else $error("frame start did not clear pattern index");

  a_keyed_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> enable_q)
    else $error("keyed word while key disabled");

endmodule

// ===== hdl/pnfd_key_gen.sv =====
module pnfd_key_gen (
  input  pnfd_pkg::key_req_t req_i,
  output logic [7:0]         key_o
);
  import pnfd_pkg::*;

  localparam int FIRST_SHIFT = 8 - FIRST_BITS_N;

  logic [IDX_W:0]   bit_sum [8];
  logic [IDX_W-1:0] bit_idx [8];
  logic [7:0]       key8;

  // Read eight consecutive pattern bits, wrapping at the period
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bit_sum[k] = {1'b0, req_i.idx} + (IDX_W+1)'(k);
      if (bit_sum[k] >= PN_PERIOD) begin
        bit_sum[k] = bit_sum[k] - PN_PERIOD;
      end
      bit_idx[k]   = bit_sum[k][IDX_W-1:0];
      key8[7 - k]  = rom_bit(bit_idx[k]);
    end
  end

  // Partial first word keeps only its leading bits, right aligned
  assign key_o = req_i.first ? (key8 >> FIRST_SHIFT) : key8;

endmodule

// ===== verif/tb_pn_frame_derandomizer_unit.sv =====
module tb_pn_frame_derandomizer_unit;
  import pnfd_pkg::*;

  // Frame geometry, kept apart from the design
  localparam int FRAME_LEN   = 4159;
  localparam int PN_LEN      = 1023;
  localparam int KEY_START   = 60;
  localparam int KEY_FIRST   = KEY_START / 8;
  localparam int KEY_STOP    = (33270 / 8 < FRAME_LEN) ? 33270 / 8 : FRAME_LEN;
  localparam int FIRST_NBITS = 8 - KEY_START % 8;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 6;

  localparam logic [2:0] ENABLE_ADDR = {REG_ENABLE, 2'b00};

  // Pseudo-noise pattern, bit 0 is the MSB of the first byte
  localparam logic [0:1023] PN_BITS = {
    8'h07, 8'h40, 8'hc9, 8'h29, 8'h42, 8'h5e, 8'hee, 8'ha8, 8'hee, 8'h2c, 8'h2f, 8'hb1,
    8'hf5, 8'h24, 8'h21, 8'hc8, 8'he6, 8'h60, 8'h36, 8'h6c, 8'h5c, 8'h79, 8'h6f, 8'h04,
    8'h9c, 8'hed, 8'h36, 8'haa, 8'hfd, 8'h2a, 8'h58, 8'hdb, 8'ha2, 8'h77, 8'h92, 8'hd6,
    8'h45, 8'h20, 8'h07, 8'hc4, 8'h08, 8'hb4, 8'h98, 8'hcb, 8'h3a, 8'h44, 8'h29, 8'h84,
    8'hff, 8'hbd, 8'h9f, 8'h31, 8'h12, 8'hb5, 8'h15, 8'h89, 8'h9c, 8'h2b, 8'h97, 8'hf9,
    8'hca, 8'hf5, 8'h66, 8'h41, 8'h06, 8'h0b, 8'h2a, 8'hdc, 8'h1a, 8'h3f, 8'had, 8'h07,
    8'h02, 8'ha9, 8'he7, 8'haf, 8'h14, 8'h04, 8'hde, 8'h8d, 8'hf8, 8'h47, 8'hb7, 8'hc0,
    8'h2e, 8'hb8, 8'h76, 8'h1f, 8'h94, 8'he3, 8'h4f, 8'hb9, 8'hb9, 8'h3d, 8'hfc, 8'h61,
    8'hbb, 8'h2e, 8'hfa, 8'h16, 8'hd1, 8'h79, 8'ha9, 8'ha5, 8'hcf, 8'hda, 8'he9, 8'h94,
    8'h67, 8'h8e, 8'h24, 8'h63, 8'ha8, 8'h28, 8'h8d, 8'h7c, 8'h86, 8'h2a, 8'h1a, 8'hbb,
    8'h6c, 8'h9a, 8'hd8, 8'h3c, 8'h33, 8'h43, 8'hd3, 8'hac
  };

  typedef struct packed {
    logic [7:0] data;
    logic       keyed;
  } clear_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;   // expectation written out below
    logic [7:0] want_data;
    logic       want_keyed;
  } dir_row_t;

  // Directed words: before any frame, header bytes, key edge, restarts
  dir_row_t dir_rows [25] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},  // no frame seen yet
    '{8'hff, 1'b0, 1'b1, 8'hff, 1'b0},
    '{8'h3c, 1'b1, 1'b1, 8'h3c, 1'b0},  // byte 0
    '{8'hff, 1'b0, 1'b1, 8'hff, 1'b0},
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
    '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
    '{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
    '{8'h7f, 1'b0, 1'b1, 8'h7f, 1'b0},
    '{8'hfe, 1'b0, 1'b1, 8'hfe, 1'b0},  // byte 6, last clear header byte
    '{8'hff, 1'b0, 1'b1, 8'hff, 1'b1},  // byte 7, key nibble is zero
    '{8'h00, 1'b0, 1'b1, 8'h74, 1'b1},  // byte 8, pattern bits 4..11
    '{8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'ha5, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h5a, 1'b1, 1'b1, 8'h5a, 1'b0},  // restart mid frame
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0},  // back-to-back start
    '{8'h11, 1'b0, 1'b1, 8'h11, 1'b0},
    '{8'h22, 1'b0, 1'b1, 8'h22, 1'b0},
    '{8'h44, 1'b0, 1'b1, 8'h44, 1'b0},
    '{8'h88, 1'b0, 1'b1, 8'h88, 1'b0},
    '{8'hee, 1'b0, 1'b1, 8'hee, 1'b0},
    '{8'h77, 1'b0, 1'b1, 8'h77, 1'b0},
    '{8'hf0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h0f, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hc3, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser  = '0;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic [0:0]  m_axis_tuser;         // [0] keyed
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic              key_enable = 1'b1;
  logic [POS_W-1:0]  frame_pos  = POS_W'(FRAME_LEN);
  logic [IDX_W-1:0]  pn_idx     = '0;

  clear_word_t descrambled_q [$];
  int          mismatches  = 0;
  int          quiet_cycles = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_out    = 1'b0;

  pn_frame_derandomizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Strip the key from one byte and advance the frame counters
  function automatic clear_word_t descramble(input logic [7:0] b, input logic st);
    clear_word_t res;
    logic [7:0]  key;
    int          nbits;
    logic        in_key;
    key = '0;
    if (st) begin
      frame_pos = '0;
      pn_idx    = '0;
    end
    in_key = (frame_pos >= KEY_FIRST) && (frame_pos < KEY_STOP);
    if (in_key) begin
      nbits = (frame_pos == KEY_FIRST) ? FIRST_NBITS : 8;
      for (int k = 0; k < nbits; k++) begin
        key    = {key[6:0], PN_BITS[pn_idx]};
        pn_idx = (pn_idx == IDX_W'(PN_LEN - 1)) ? '0 : pn_idx + 1'b1;
      end
    end
    res.data  = (in_key && key_enable) ? (b ^ key) : b;
    res.keyed = in_key && key_enable;
    if (frame_pos < FRAME_LEN) frame_pos = frame_pos + 1'b1;
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    mismatches++;
  endfunction

  // Mostly random bytes, with the all-zero and all-one values favored
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one word, hold it until accepted, then queue its expected output
  task automatic send_word(input logic [7:0] b, input logic st);
    clear_word_t next_word;
    while (gaps_on && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    next_word = descramble(b, st);
    descrambled_q.insert(descrambled_q.size(), next_word);
  endtask

  task automatic send_plain(input int n);
    repeat (n) send_word(rand_byte(), 1'b0);
  endtask

  // Mostly whole frames of random length, some loose bytes and repeated starts
  task automatic send_random(input int n, input bit carry_on);
    int sent;
    int len;
    int pick;
    sent = 0;
    if (carry_on) begin
      len = $urandom_range(50, 150);
      send_plain(len);
      sent += len;
    end
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 300);
        send_word(rand_byte(), 1'b1);
        send_plain(len - 1);
      end else if (pick < 93) begin
        len = $urandom_range(1, 20);
        send_plain(len);
      end else begin
        len = $urandom_range(2, 4);
        repeat (len) send_word(rand_byte(), 1'b1);
      end
      sent += len;
    end
  endtask

  // Stop offering and wait for every expected word to come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (descrambled_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the enable register, then read it back
  task automatic set_enable(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    key_enable = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(v)) flag_mismatch("enable readback", 32'(v), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (gaps_on) begin
        m_axis_tready <= ($urandom_range(99) >= 29);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    clear_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (descrambled_q.size() == 0) begin
        flag_mismatch("unexpected word", '0, {23'b0, m_axis_tdata, m_axis_tuser});
      end else begin
        want = descrambled_q.pop_front();
        if (m_axis_tdata !== want.data)
          flag_mismatch("out_byte", 32'(want.data), 32'(m_axis_tdata));
        if (m_axis_tuser[0] !== want.keyed)
          flag_mismatch("keyed", 32'(want.keyed), 32'(m_axis_tuser));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pn_frame_derandomizer_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset setting
    foreach (dir_rows[r]) begin
      send_word(dir_rows[r].data, dir_rows[r].start);
      if (dir_rows[r].typed)
        descrambled_q[descrambled_q.size() - 1] = '{dir_rows[r].want_data,
                                                     dir_rows[r].want_keyed};
    end
    drain();

    // Keyed frames, with one long receiver hold-off in the middle
    set_enable(1'b1);
    send_random(80, 1'b0);
    hold_out = 1'b1;
    send_random(120, 1'b0);
    drain();

    // Key off, continuing the open frame so the counters keep moving
    set_enable(1'b0);
    send_random(120, 1'b1);
    drain();

    // Key on again, no idling on either side
    gaps_on = 1'b0;
    set_enable(1'b1);
    send_random(150, 1'b1);
    drain();
    gaps_on = 1'b1;

    // One frame with the key toggled midway
    send_word(rand_byte(), 1'b1);
    send_plain(59);
    drain();
    set_enable(1'b0);
    send_plain(40);
    drain();
    set_enable(1'b1);
    send_plain(40);
    drain();

    if (mismatches == 0 && descrambled_q.size() == 0) begin
      $display("pn_frame_derandomizer_unit test passed");
    end else begin
      $display("pn_frame_derandomizer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pnfd_pkg.sv
hdl/pnfd_key_gen.sv
hdl/pn_frame_derandomizer_unit.sv
verif/tb_pn_frame_derandomizer_unit.sv
